[sv/vcs_pkg.sv]
// Shared constants for the vector cosine similarity unit.
`timescale 1ns / 1ps

package vcs_pkg;

    // Default component width and number of fraction bits of the result
    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int FRACTION_BITS_DEF   = 14;

    // Dimension codes
    localparam logic [2:0] DIMS_THREE = 3'd3;
    localparam logic [2:0] DIMS_FOUR  = 3'd4;

    // Number of component lanes
    localparam int LANES = 4;

endpackage

[sv/vector_cosine_similarity_unit.sv]
// Throughput: one vector pair per cycle; a stalled result holds the whole pipeline.
// Most of the pipeline depth is the one-bit-per-stage result search (FRACTION_BITS + 1 stages).
// Reset: synchronous active-low aresetn clears all stage valid bits; data registers
// are not reset.
`timescale 1ns / 1ps

module vector_cosine_similarity_unit #(
    parameter int COMPONENT_WIDTH = vcs_pkg::COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = vcs_pkg::FRACTION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_dims,
    input  logic signed [COMPONENT_WIDTH-1:0] s_a_x,
    input  logic signed [COMPONENT_WIDTH-1:0] s_a_y,
    input  logic signed [COMPONENT_WIDTH-1:0] s_a_z,
    input  logic signed [COMPONENT_WIDTH-1:0] s_a_w,
    input  logic signed [COMPONENT_WIDTH-1:0] s_b_x,
    input  logic signed [COMPONENT_WIDTH-1:0] s_b_y,
    input  logic signed [COMPONENT_WIDTH-1:0] s_b_z,
    input  logic signed [COMPONENT_WIDTH-1:0] s_b_w,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [FRACTION_BITS+1:0]   m_cosine,
    output logic                              m_zero_vector
);
    import vcs_pkg::*;

    localparam int CW  = COMPONENT_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int PW  = 2 * CW;          // one component product
    localparam int NW  = 2 * CW + 1;      // squared norm, unsigned
    localparam int DW  = 2 * CW + 2;      // dot product, signed
    localparam int LH  = (NW + 1) / 2;    // low half of split multiplier operand
    localparam int HH  = NW - LH;         // high half
    localparam int QW  = 2 * NW;          // product of two norms
    localparam int SW  = 4 * CW + 2 * F + 8; // search accumulators, signed
    localparam int RW  = F + 1;           // result magnitude
    localparam int OW  = F + 2;           // result port

    // Global pipeline advance: move when the output is free or being taken
    logic ce;
    assign ce      = m_ready | ~m_valid;
    assign s_ready = ce;

    // ---------------- Stage 1: component products ----------------
    logic signed [CW-1:0] a_in [LANES];
    logic signed [CW-1:0] b_in [LANES];
    logic                 use_z, use_w;

    assign use_z = (s_dims >= DIMS_THREE);
    assign use_w = (s_dims >= DIMS_FOUR);

    always_comb begin
        a_in[0] = s_a_x;
        a_in[1] = s_a_y;
        a_in[2] = use_z ? s_a_z : '0;
        a_in[3] = use_w ? s_a_w : '0;
        b_in[0] = s_b_x;
        b_in[1] = s_b_y;
        b_in[2] = use_z ? s_b_z : '0;
        b_in[3] = use_w ? s_b_w : '0;
    end

    logic                 v1_reg;
    logic [PW-1:0]        aa_reg [LANES];
    logic [PW-1:0]        bb_reg [LANES];
    logic signed [PW-1:0] ab_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < LANES; i++) begin
                aa_reg[i] <= unsigned'(PW'(a_in[i] * a_in[i]));
                bb_reg[i] <= unsigned'(PW'(b_in[i] * b_in[i]));
                ab_reg[i] <= PW'(a_in[i] * b_in[i]);
            end
        end
    end

    // ---------------- Stage 2: norms and dot product ----------------
    logic                 v2_reg;
    logic [NW-1:0]        na_reg, nb_reg;
    logic signed [DW-1:0] dot_reg;
    logic [NW-1:0]        na_next, nb_next;
    logic signed [DW-1:0] dot_next;

    always_comb begin
        na_next  = '0;
        nb_next  = '0;
        dot_next = '0;
        for (int i = 0; i < LANES; i++) begin
            na_next  = na_next + NW'(aa_reg[i]);
            nb_next  = nb_next + NW'(bb_reg[i]);
            dot_next = dot_next + DW'(ab_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            na_reg  <= na_next;
            nb_reg  <= nb_next;
            dot_reg <= dot_next;
        end
    end

    // ---------------- Stage 3: flags, |dot|, split partial products ----------------
    logic                 neg_dot;
    logic [NW-1:0]        dmag;
    logic signed [DW-1:0] dot_abs;

    assign neg_dot = dot_reg[DW-1];
    assign dot_abs = neg_dot ? -dot_reg : dot_reg;
    assign dmag    = dot_abs[NW-1:0];

    logic               v3_reg, z3_reg, n3_reg;
    logic [NW+LH-1:0]   plo_reg, dlo_reg;
    logic [NW+HH-1:0]   phi_reg, dhi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ce) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            z3_reg  <= (na_reg == '0) || (nb_reg == '0);
            n3_reg  <= neg_dot;
            plo_reg <= (NW+LH)'(na_reg) * (NW+LH)'(nb_reg[LH-1:0]);
            phi_reg <= (NW+HH)'(na_reg) * (NW+HH)'(nb_reg[NW-1:LH]);
            dlo_reg <= (NW+LH)'(dmag) * (NW+LH)'(dmag[LH-1:0]);
            dhi_reg <= (NW+HH)'(dmag) * (NW+HH)'(dmag[NW-1:LH]);
        end
    end

    // ---------------- Stage 4: recombine norm product and dot squared ----------------
    logic [QW-1:0] p4_next, d4_next;

    assign p4_next = QW'(plo_reg) + (QW'(phi_reg) << LH);
    assign d4_next = QW'(dlo_reg) + (QW'(dhi_reg) << LH);

    // ---------------- Result search: one bit per stage, MSB first ----------------
    // Finds the largest r in [0, 2^F] with (2r-1)^2 * P <= 2^(2F+2) * dot^2.
    // bs_s holds (2r-1)^2 * P and bs_t holds (2r-1) * P, updated by shifts and adds.
    // Entry 0 is the stage 4 register, loaded with r = 0 (q = -1).
    logic                 bs_v_reg   [F+2];
    logic                 bs_z_reg   [F+2];
    logic                 bs_n_reg   [F+2];
    logic [RW-1:0]        bs_r_reg   [F+2];
    logic signed [SW-1:0] bs_s_reg   [F+2];
    logic signed [SW-1:0] bs_t_reg   [F+2];
    logic signed [SW-1:0] bs_p_reg   [F+2];
    logic signed [SW-1:0] bs_rhs_reg [F+2];

    localparam logic [RW-1:0] R_MAX = RW'(1) << F;

    logic signed [SW-1:0] cand_s [F+1];
    logic [RW-1:0]        cand_r [F+1];
    logic                 take   [F+1];

    // Trial of bit F-j at search step j
    always_comb begin
        for (int j = 0; j <= F; j++) begin
            cand_s[j] = bs_s_reg[j] + (bs_t_reg[j] <<< (F - j + 2))
                        + (bs_p_reg[j] <<< (2 * (F - j) + 2));
            cand_r[j] = bs_r_reg[j] | (RW'(1) << (F - j));
            take[j]   = (cand_s[j] <= bs_rhs_reg[j]) && (cand_r[j] <= R_MAX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= F + 1; j++) begin
                bs_v_reg[j] <= 1'b0;
            end
        end else if (ce) begin
            bs_v_reg[0] <= v3_reg;
            for (int j = 0; j <= F; j++) begin
                bs_v_reg[j+1] <= bs_v_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            bs_z_reg[0]   <= z3_reg;
            bs_n_reg[0]   <= n3_reg;
            bs_r_reg[0]   <= '0;
            bs_s_reg[0]   <= signed'(SW'(p4_next));
            bs_t_reg[0]   <= -signed'(SW'(p4_next));
            bs_p_reg[0]   <= signed'(SW'(p4_next));
            bs_rhs_reg[0] <= signed'(SW'(d4_next)) <<< (2 * F + 2);
            for (int j = 0; j <= F; j++) begin
                bs_z_reg[j+1]   <= bs_z_reg[j];
                bs_n_reg[j+1]   <= bs_n_reg[j];
                bs_p_reg[j+1]   <= bs_p_reg[j];
                bs_rhs_reg[j+1] <= bs_rhs_reg[j];
                bs_r_reg[j+1]   <= take[j] ? cand_r[j] : bs_r_reg[j];
                bs_s_reg[j+1]   <= take[j] ? cand_s[j] : bs_s_reg[j];
                bs_t_reg[j+1]   <= take[j] ? (bs_t_reg[j] + (bs_p_reg[j] <<< (F - j + 1)))
                                           : bs_t_reg[j];
            end
        end
    end

    // ---------------- Output register ----------------
    logic                 out_v_reg, out_z_reg;
    logic signed [OW-1:0] out_c_reg;
    logic signed [OW-1:0] mag_s;

    assign mag_s = signed'(OW'(bs_r_reg[F+1]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (ce) begin
            out_v_reg <= bs_v_reg[F+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_z_reg <= bs_z_reg[F+1];
            if (bs_z_reg[F+1]) begin
                out_c_reg <= '0;
            end else begin
                out_c_reg <= bs_n_reg[F+1] ? -mag_s : mag_s;
            end
        end
    end

    assign m_valid       = out_v_reg;
    assign m_cosine      = out_c_reg;
    assign m_zero_vector = out_z_reg;

    // ---------------- Assertions ----------------
    localparam logic signed [OW-1:0] C_MAX = OW'(1) << F;

    a_zero_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_vector) |-> (m_cosine == '0))
        else $error("zero-length flag with nonzero cosine");

    a_cosine_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_cosine <= C_MAX) && (m_cosine >= -C_MAX)))
        else $error("cosine out of range");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

[tb/sv/vector_cosine_similarity_unit_tb.sv]
// Testbench for the vector cosine similarity unit: random and directed vector pairs.
`timescale 1ns / 1ps

module vector_cosine_similarity_unit_tb;
    import vcs_pkg::*;

    localparam int CW      = COMPONENT_WIDTH_DEF;
    localparam int FB      = FRACTION_BITS_DEF;
    localparam int LATENCY = FB + 6;
    localparam int N_RANDOM = 1850;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [2:0]           dims;
        logic signed [CW-1:0] a [LANES];
        logic signed [CW-1:0] b [LANES];
    } pair_t;

    typedef struct {
        logic signed [FB+1:0] cosine;
        logic                 zero_vector;
    } cos_result_t;

    // Scoreboard: computes the exact cosine of each request and checks results in order
    class cosine_scoreboard;
        cos_result_t pending[$];
        int errors;
        int n_checked;
        int n_zero;

        function automatic cos_result_t compute_cosine(pair_t p);
            cos_result_t  r;
            int           n;
            longint       av, bv;
            logic [127:0] len_a, len_b, pos, neg, dot, prod, rhs, lhs;
            longint       lo, hi, mid, q;
            bit           negative;
            n = p.dims;
            if (n < 2) n = 2;
            if (n > LANES) n = LANES;
            len_a = 0; len_b = 0; pos = 0; neg = 0;
            for (int i = 0; i < n; i++) begin
                av = p.a[i];
                bv = p.b[i];
                len_a += 128'(av * av);
                len_b += 128'(bv * bv);
                if ((av < 0) != (bv < 0) && av != 0 && bv != 0)
                    neg += 128'((av < 0 ? -av : av) * (bv < 0 ? -bv : bv));
                else
                    pos += 128'((av < 0 ? -av : av) * (bv < 0 ? -bv : bv));
            end
            if (len_a == 0 || len_b == 0) begin
                r.cosine = '0;
                r.zero_vector = 1'b1;
                return r;
            end
            negative = neg > pos;
            dot  = negative ? neg - pos : pos - neg;
            prod = len_a * len_b;
            rhs  = (dot * dot) << (2 * FB + 2);
            // largest r with (2r-1)^2 * |a|^2|b|^2 <= 2^(2F+2) * dot^2
            lo = 0;
            hi = longint'(1) << FB;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                q   = 2 * mid - 1;
                lhs = 128'(q * q) * prod;
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
            r.cosine = negative ? -(FB+2)'(lo) : (FB+2)'(lo);
            r.zero_vector = 1'b0;
            return r;
        endfunction

        function void note_request(pair_t p);
            pending.push_back(compute_cosine(p));
        endfunction

        function void check_result(logic signed [FB+1:0] cosine, logic zero_vector);
            cos_result_t e;
            if (pending.size() == 0) begin
                $error("result with no request pending: cosine=%0d zero_vector=%0b",
                       cosine, zero_vector);
                errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (e.zero_vector) n_zero++;
            if (cosine !== e.cosine) begin
                $error("cosine mismatch: expected %0d actual %0d", e.cosine, cosine);
                errors++;
            end
            if (zero_vector !== e.zero_vector) begin
                $error("zero_vector mismatch: expected %0b actual %0b",
                       e.zero_vector, zero_vector);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [2:0]           s_dims;
    logic signed [CW-1:0] s_a_x, s_a_y, s_a_z, s_a_w;
    logic signed [CW-1:0] s_b_x, s_b_y, s_b_z, s_b_w;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [FB+1:0] m_cosine;
    logic                 m_zero_vector;

    cosine_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    int  hold_left;
    int  n_sent;

    vector_cosine_similarity_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_dims        (s_dims),
        .s_a_x         (s_a_x),
        .s_a_y         (s_a_y),
        .s_a_z         (s_a_z),
        .s_a_w         (s_a_w),
        .s_b_x         (s_b_x),
        .s_b_y         (s_b_y),
        .s_b_z         (s_b_z),
        .s_b_w         (s_b_w),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cosine      (m_cosine),
        .m_zero_vector (m_zero_vector)
    );

    // 20 ns clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: check accepted results, random back-pressure, long hold-off on demand
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_cosine, m_zero_vector);
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one request and wait for it to be taken, then maybe idle
    task automatic send_pair(pair_t p);
        s_valid <= 1'b1;
        s_dims  <= p.dims;
        s_a_x <= p.a[0]; s_a_y <= p.a[1]; s_a_z <= p.a[2]; s_a_w <= p.a[3];
        s_b_x <= p.b[0]; s_b_y <= p.b[1]; s_b_z <= p.b[2]; s_b_w <= p.b[3];
        do @(posedge aclk); while (!s_ready);
        sb.note_request(p);
        n_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic pair_t make_pair(logic [2:0] dims,
                                        int ax, int ay, int az, int aw,
                                        int bx, int by, int bz, int bw);
        pair_t p;
        p.dims = dims;
        p.a[0] = CW'(ax); p.a[1] = CW'(ay); p.a[2] = CW'(az); p.a[3] = CW'(aw);
        p.b[0] = CW'(bx); p.b[1] = CW'(by); p.b[2] = CW'(bz); p.b[3] = CW'(bw);
        return p;
    endfunction

    function automatic logic signed [CW-1:0] pick_edge();
        case ($urandom_range(5))
            0: return CW'(-(2 ** (CW - 1)));
            1: return CW'(2 ** (CW - 1) - 1);
            2: return '0;
            3: return CW'(1);
            4: return CW'(-1);
            default: return CW'($urandom);
        endcase
    endfunction

    // Random request: mostly meaningful shapes, some raw noise
    function automatic pair_t random_pair();
        pair_t p;
        int    kind;
        int    k;
        p.dims = ($urandom_range(9) < 8) ? 3'($urandom_range(4, 2)) : 3'($urandom_range(7));
        kind = $urandom_range(99);
        for (int i = 0; i < LANES; i++) begin
            if (kind < 40) begin
                p.a[i] = CW'($urandom);
                p.b[i] = CW'($urandom);
            end else if (kind < 60) begin
                p.a[i] = CW'($urandom_range(16) - 8);
                p.b[i] = CW'($urandom_range(16) - 8);
            end else if (kind < 75) begin
                // nearly parallel or antiparallel
                k = $urandom_range(1) ? 1 : -1;
                p.a[i] = CW'($urandom_range(32766) - 16383);
                p.b[i] = CW'(k * p.a[i] + int'($urandom_range(4)) - 2);
            end else if (kind < 90) begin
                p.a[i] = pick_edge();
                p.b[i] = pick_edge();
            end else begin
                p.a[i] = (kind < 95) ? '0 : CW'($urandom);
                p.b[i] = (kind < 95) ? CW'($urandom) : '0;
            end
        end
        return p;
    endfunction

    initial begin
        pair_t directed [$];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_dims  = '0;
        {s_a_x, s_a_y, s_a_z, s_a_w} = '0;
        {s_b_x, s_b_y, s_b_z, s_b_w} = '0;
        m_ready = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        n_sent = 0;
        sb = new();
        send_idle_pct = 11;
        recv_idle_pct = 55;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, all dimension codes, zero vectors, parallel cases
        directed.push_back(make_pair(3'd2, 1, 0, 0, 0, 1, 0, 0, 0));
        directed.push_back(make_pair(3'd2, 1, 0, 0, 0, -1, 0, 0, 0));
        directed.push_back(make_pair(3'd2, 1, 0, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_pair(3'd2, 0, 0, 5, 5, 3, 4, 0, 0));
        directed.push_back(make_pair(3'd2, 3, 4, 0, 0, 0, 0, 7, 7));
        directed.push_back(make_pair(DIMS_THREE, 0, 0, 1, 0, 0, 0, 1, 0));
        directed.push_back(make_pair(DIMS_FOUR, 0, 0, 0, -5, 0, 0, 0, 9));
        directed.push_back(make_pair(3'd0, 1, 1, 9, 9, 1, 1, -9, -9));
        directed.push_back(make_pair(3'd1, 1, 2, 9, 9, 2, 1, 9, 9));
        directed.push_back(make_pair(3'd5, 1, 1, 1, 1, 1, 1, 1, -1));
        directed.push_back(make_pair(3'd7, -1, 2, -3, 4, 4, -3, 2, -1));
        directed.push_back(make_pair(3'd6, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_pair(DIMS_FOUR, -32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, -32768));
        directed.push_back(make_pair(DIMS_FOUR, -32768, -32768, -32768, -32768,
                                     32767, 32767, 32767, 32767));
        directed.push_back(make_pair(DIMS_FOUR, 32767, -32768, 32767, -32768,
                                     -32768, 32767, -32768, 32767));
        directed.push_back(make_pair(DIMS_THREE, 32767, 32767, 32767, 0, 32767, 32767, 32767, 0));
        directed.push_back(make_pair(3'd2, 32767, -32768, 0, 0, 1, 1, 0, 0));
        directed.push_back(make_pair(3'd2, 1, 1, 0, 0, 1, 0, 0, 0));
        directed.push_back(make_pair(3'd2, 1, 2, 0, 0, 2, -1, 0, 0));
        directed.push_back(make_pair(DIMS_THREE, 1, 0, 0, 0, 1, 1, 1, 0));
        foreach (directed[i]) send_pair(directed[i]);

        // random phases: sender light / receiver heavy, swapped, then none
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                send_idle_pct = 55;
                recv_idle_pct = 11;
            end
            if (i == 2 * N_RANDOM / 3) begin
                // sender waits out everything in flight before the full-rate phase
                wait_drained();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (i == 2 * N_RANDOM / 3 + 50) hold_req = 1'b1;
            send_pair(random_pair());
        end
        s_valid <= 1'b0;

        fork
            begin
                while (sb.pending.size() != 0) @(posedge aclk);
                repeat (LATENCY + 10) @(posedge aclk);
            end
            begin
                repeat (HOLD_CYCLES + 50 * LATENCY) @(posedge aclk);
            end
        join_any
        disable fork;
        if (sb.pending.size() != 0) begin
            $error("%0d results never arrived", sb.pending.size());
            sb.errors++;
        end

        $display("Covered %0d vector pairs (%0d checked, %0d with a zero-length vector)",
                 n_sent, sb.n_checked, sb.n_zero);
        $display("with dims 0..7, component extremes, back-pressure and a long output stall");
        if (sb.errors == 0) begin
            $display("vector_cosine_similarity_unit_tb OK");
        end else begin
            $display("vector_cosine_similarity_unit_tb NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("vector_cosine_similarity_unit_tb NOT OK");
        $finish;
    end

endmodule
